@@ design/climate_hysteresis_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Climate hysteresis controller assertion macros
// Shared property forms for the controller's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CLIMATE_HYSTERESIS_CONTROLLER_ASSERT_SVH
`define CLIMATE_HYSTERESIS_CONTROLLER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/chc_pkg.sv @@
// ----------------------------------------------------------------------------
// chc_pkg
// Word types, mode codes, register map and constants of the climate controller.
// ----------------------------------------------------------------------------
package chc_pkg;

	typedef enum logic [1:0] {
		MODE_AUTO     = 2'd0,
		MODE_MANUAL   = 2'd1,
		MODE_SCHEDULE = 2'd2
	} mode_t;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_MODE   = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [1:0]        new_mode;
		logic [31:0]       now_ms;
		logic signed [11:0] temperature;
		logic              temp_valid;
		logic [9:0]        humidity;
		logic              humid_valid;
	} req_word_t;

	typedef struct packed {
		logic       heater_on;
		logic       fan_on;
		logic       humidifier_on;
		logic       servo_extended;
		logic [7:0] servo_angle;
		logic       turn_event;
		logic       alert_high_event;
		logic       alert_low_event;
		logic [1:0] mode_now;
	} rsp_word_t;

	// register map, word index = paddr[4:2]
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [2:0] REG_TEMP_MIN      = 3'd0;
	localparam logic [2:0] REG_TEMP_MAX      = 3'd1;
	localparam logic [2:0] REG_HYSTERESIS    = 3'd2;
	localparam logic [2:0] REG_HUMID_MIN     = 3'd3;
	localparam logic [2:0] REG_HUMID_MAX     = 3'd4;
	localparam logic [2:0] REG_TURN_INTERVAL = 3'd5;
	localparam logic [2:0] REG_EXTEND_ANGLE  = 3'd6;
	localparam logic [2:0] REG_RETRACT_ANGLE = 3'd7;

	localparam logic [11:0] TEMP_MIN_RESET      = 12'd370;
	localparam logic [11:0] TEMP_MAX_RESET      = 12'd380;
	localparam logic [8:0]  HYSTERESIS_RESET    = 9'd5;
	localparam logic [9:0]  HUMID_MIN_RESET     = 10'd550;
	localparam logic [9:0]  HUMID_MAX_RESET     = 10'd650;
	localparam logic [10:0] TURN_INTERVAL_RESET = 11'd120;
	localparam logic [7:0]  EXTEND_ANGLE_RESET  = 8'd180;
	localparam logic [7:0]  RETRACT_ANGLE_RESET = 8'd0;

	// turn interval in ms: 11-bit minutes times 60000 fits 27 bits
	localparam int unsigned INTERVAL_W = 27;
	localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET =
		INTERVAL_W'(120 * 60000);

	// alert thresholds, tenths of a degree, on a 14-bit signed compare path
	localparam logic signed [13:0] ALERT_MARGIN  = 14'sd20;
	localparam logic signed [13:0] ALERT_RELEASE = 14'sd10;

endpackage

@@ design/climate_hysteresis_controller.sv @@
// ----------------------------------------------------------------------------
// climate_hysteresis_controller
// Hysteresis thermostat with critical alerts, humidifier control and a timed
// servo, one request word in and one response word out.
// ----------------------------------------------------------------------------
// Each request word is either a mode command or a sensor sample, and each one
// produces exactly one response word carrying the relay states, servo position
// and angle, event pulses and the mode in force. The block takes one word per
// clock while req_stall is low: a word is captured into the input register,
// evaluated there against the controller state, and lands in the response
// register when it advances, which raises rsp_valid; the response word leaves
// while rsp_stall is low. The sustained rate is one word per cycle when
// rsp_stall stays low, set by the single evaluation stage that updates the
// state. req_stall rises only while the input register is full and the
// response register is held by rsp_stall. Critical alerts run in every mode
// on valid temperatures; relays and the servo move only in auto mode, and a
// switch into auto clears all three relays. The servo interval is kept in
// milliseconds alongside the minute register, worked out when the register is
// written. Registers sit at byte address 4*i on the APB port (paddr[4:2]) and
// should be written only while no word is in flight.
// ----------------------------------------------------------------------------
`include "climate_hysteresis_controller_assert.svh"

module climate_hysteresis_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             req_valid,
	output logic                             req_stall,
	input  chc_pkg::req_word_t               req,
	// response channel
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output chc_pkg::rsp_word_t               rsp,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [chc_pkg::ADDR_W-1:0]       paddr,
	input  logic [chc_pkg::DATA_W-1:0]       pwdata,
	output logic [chc_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);

	// ---------------------------------------------------------------- config
	logic [11:0]                      temp_min_q;
	logic [11:0]                      temp_max_q;
	logic [8:0]                       hyst_q;
	logic [9:0]                       humid_min_q;
	logic [9:0]                       humid_max_q;
	logic [10:0]                      turn_min_q;
	logic [chc_pkg::INTERVAL_W-1:0]   interval_ms_q;
	logic [7:0]                       extend_q;
	logic [7:0]                       retract_q;

	logic                             cfg_wr;
	logic [2:0]                       cfg_idx;
	logic [chc_pkg::INTERVAL_W-1:0]   interval_wr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	// minutes to ms for the interval register, done once per write
	assign interval_wr = chc_pkg::INTERVAL_W'(pwdata[10:0])
		* chc_pkg::INTERVAL_W'(chc_pkg::MS_PER_MINUTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_min_q    <= chc_pkg::TEMP_MIN_RESET;
			temp_max_q    <= chc_pkg::TEMP_MAX_RESET;
			hyst_q        <= chc_pkg::HYSTERESIS_RESET;
			humid_min_q   <= chc_pkg::HUMID_MIN_RESET;
			humid_max_q   <= chc_pkg::HUMID_MAX_RESET;
			turn_min_q    <= chc_pkg::TURN_INTERVAL_RESET;
			interval_ms_q <= chc_pkg::INTERVAL_RESET;
			extend_q      <= chc_pkg::EXTEND_ANGLE_RESET;
			retract_q     <= chc_pkg::RETRACT_ANGLE_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				chc_pkg::REG_TEMP_MIN:      temp_min_q  <= pwdata[11:0];
				chc_pkg::REG_TEMP_MAX:      temp_max_q  <= pwdata[11:0];
				chc_pkg::REG_HYSTERESIS:    hyst_q      <= pwdata[8:0];
				chc_pkg::REG_HUMID_MIN:     humid_min_q <= pwdata[9:0];
				chc_pkg::REG_HUMID_MAX:     humid_max_q <= pwdata[9:0];
				chc_pkg::REG_TURN_INTERVAL: begin
					turn_min_q    <= pwdata[10:0];
					interval_ms_q <= interval_wr;
				end
				chc_pkg::REG_EXTEND_ANGLE:  extend_q    <= pwdata[7:0];
				chc_pkg::REG_RETRACT_ANGLE: retract_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// readback returns the raw register bits, zero-extended
	always_comb begin
		unique case (cfg_idx)
			chc_pkg::REG_TEMP_MIN:      prdata = chc_pkg::DATA_W'(temp_min_q);
			chc_pkg::REG_TEMP_MAX:      prdata = chc_pkg::DATA_W'(temp_max_q);
			chc_pkg::REG_HYSTERESIS:    prdata = chc_pkg::DATA_W'(hyst_q);
			chc_pkg::REG_HUMID_MIN:     prdata = chc_pkg::DATA_W'(humid_min_q);
			chc_pkg::REG_HUMID_MAX:     prdata = chc_pkg::DATA_W'(humid_max_q);
			chc_pkg::REG_TURN_INTERVAL: prdata = chc_pkg::DATA_W'(turn_min_q);
			chc_pkg::REG_EXTEND_ANGLE:  prdata = chc_pkg::DATA_W'(extend_q);
			chc_pkg::REG_RETRACT_ANGLE: prdata = chc_pkg::DATA_W'(retract_q);
			default:                    prdata = '0;
		endcase
	end

	// -------------------------------------------------------------- pipeline
	// Stage 1 holds the accepted word; stage 2 is the response register.
	// Advance stage 1 whenever the response register is empty or draining.
	chc_pkg::req_word_t req_s1;
	logic               valid_s1;
	chc_pkg::rsp_word_t rsp_s2;
	logic               valid_s2;
	logic               advance;
	logic               req_take;

	assign advance   = valid_s1 & (~valid_s2 | ~rsp_stall);
	assign req_stall = valid_s1 & ~advance;
	assign req_take  = req_valid & ~req_stall;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// ----------------------------------------------------------------- state
	chc_pkg::mode_t mode_q;
	logic           heater_q;
	logic           fan_q;
	logic           humidifier_q;
	logic           servo_q;
	logic           high_alert_q;
	logic           low_alert_q;
	logic [31:0]    last_turn_q;

	chc_pkg::mode_t mode_d;
	logic           heater_d;
	logic           fan_d;
	logic           humidifier_d;
	logic           servo_d;
	logic           high_alert_d;
	logic           low_alert_d;
	logic [31:0]    last_turn_d;
	logic           turn_ev;
	logic           high_ev;
	logic           low_ev;

	// temperatures on a 14-bit signed path, room for limit plus band
	logic signed [13:0] t_x;
	logic signed [13:0] tmin_x;
	logic signed [13:0] tmax_x;
	logic signed [13:0] hyst_x;
	logic signed [13:0] hi_lim;
	logic signed [13:0] lo_lim;
	logic [10:0]        hmin_band;
	logic [31:0]        elapsed;

	assign t_x       = 14'(req_s1.temperature);
	assign tmin_x    = 14'(signed'(temp_min_q));
	assign tmax_x    = 14'(signed'(temp_max_q));
	assign hyst_x    = signed'({5'b0, hyst_q});
	assign hi_lim    = tmax_x + chc_pkg::ALERT_MARGIN;
	assign lo_lim    = tmin_x - chc_pkg::ALERT_MARGIN;
	assign hmin_band = 11'(humid_min_q) + 11'(hyst_q);
	assign elapsed   = req_s1.now_ms - last_turn_q;

	always_comb begin
		mode_d       = mode_q;
		heater_d     = heater_q;
		fan_d        = fan_q;
		humidifier_d = humidifier_q;
		servo_d      = servo_q;
		high_alert_d = high_alert_q;
		low_alert_d  = low_alert_q;
		last_turn_d  = last_turn_q;
		turn_ev      = 1'b0;
		high_ev      = 1'b0;
		low_ev       = 1'b0;

		if (req_s1.cmd == chc_pkg::CMD_MODE) begin
			// drop the unused code, ignore a repeat of the mode in force
			if (req_s1.new_mode <= chc_pkg::MODE_SCHEDULE
					&& req_s1.new_mode != mode_q) begin
				mode_d = chc_pkg::mode_t'(req_s1.new_mode);
				if (req_s1.new_mode == chc_pkg::MODE_AUTO) begin
					heater_d     = 1'b0;
					fan_d        = 1'b0;
					humidifier_d = 1'b0;
				end
			end
		end else begin
			// critical alerts, every mode; latch on raise, release 1.0 inside
			if (req_s1.temp_valid) begin
				if (t_x >= hi_lim && !high_alert_q) begin
					high_alert_d = 1'b1;
					high_ev      = 1'b1;
				end else if (t_x < hi_lim - chc_pkg::ALERT_RELEASE) begin
					high_alert_d = 1'b0;
				end
				if (t_x <= lo_lim && !low_alert_q) begin
					low_alert_d = 1'b1;
					low_ev      = 1'b1;
				end else if (t_x > lo_lim + chc_pkg::ALERT_RELEASE) begin
					low_alert_d = 1'b0;
				end
			end

			if (mode_q == chc_pkg::MODE_AUTO) begin
				if (req_s1.temp_valid) begin
					if (t_x < tmin_x) begin
						heater_d = 1'b1;
					end else if (t_x > tmin_x + hyst_x || t_x > tmax_x) begin
						heater_d = 1'b0;
					end
					if (t_x > tmax_x + hyst_x) begin
						fan_d = 1'b1;
					end else if (t_x < tmax_x) begin
						fan_d = 1'b0;
					end
				end
				if (req_s1.humid_valid) begin
					if (req_s1.humidity < humid_min_q) begin
						humidifier_d = 1'b1;
					end else if (11'(req_s1.humidity) > hmin_band
							|| req_s1.humidity > humid_max_q) begin
						humidifier_d = 1'b0;
					end
				end
				// wrapping elapsed time against the interval in ms
				if (elapsed >= 32'(interval_ms_q)) begin
					last_turn_d = req_s1.now_ms;
					servo_d     = ~servo_q;
					turn_ev     = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= chc_pkg::MODE_AUTO;
			heater_q     <= 1'b0;
			fan_q        <= 1'b0;
			humidifier_q <= 1'b0;
			servo_q      <= 1'b0;
			high_alert_q <= 1'b0;
			low_alert_q  <= 1'b0;
			last_turn_q  <= '0;
		end else if (advance) begin
			mode_q       <= mode_d;
			heater_q     <= heater_d;
			fan_q        <= fan_d;
			humidifier_q <= humidifier_d;
			servo_q      <= servo_d;
			high_alert_q <= high_alert_d;
			low_alert_q  <= low_alert_d;
			last_turn_q  <= last_turn_d;
		end
	end

	// response word built from the post-item state
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2.heater_on        <= heater_d;
			rsp_s2.fan_on           <= fan_d;
			rsp_s2.humidifier_on    <= humidifier_d;
			rsp_s2.servo_extended   <= servo_d;
			rsp_s2.servo_angle      <= servo_d ? extend_q : retract_q;
			rsp_s2.turn_event       <= turn_ev;
			rsp_s2.alert_high_event <= high_ev;
			rsp_s2.alert_low_event  <= low_ev;
			rsp_s2.mode_now         <= mode_d;
		end
	end

	// ------------------------------------------------------------ assertions
	`CHC_ASSERT_NOW(a_stall_only_when_full, req_stall,
		valid_s1 && valid_s2 && rsp_stall, "request stalled while a stage is free")
	`CHC_ASSERT_NEXT(a_advance_fills_rsp, advance, valid_s2,
		"evaluated word did not reach the response register")
	`CHC_ASSERT_NOW(a_turn_only_in_auto, valid_s2 && rsp_s2.turn_event,
		rsp_s2.mode_now == chc_pkg::MODE_AUTO, "servo turned outside auto mode")

endmodule
